// File: rtl/selective_repeat_receive_window_defines.svh
// Assertion helpers used by the receive window datapath.
// Both expect signals named clock and reset in the module that uses them.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRRW_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("receive window check failed");

// Next-cycle implication, checked outside reset.
`define SRRW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("receive window check failed");

`endif

// File: rtl/srrw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srrw_pkg;

   localparam int SRRW_RECV_SLOTS_DEF = 16;

   localparam int OP_W   = 2;
   localparam int SEQ_W  = 8;
   localparam int DATA_W = 64;
   localparam int WIN_W  = 5;

   localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
   localparam logic [OP_W-1:0] OP_PROBE   = 2'd1;
   localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
   localparam logic [OP_W-1:0] OP_READ    = 2'd3;

   localparam logic [SEQ_W-1:0] SEQ_FIRST = 8'd1;
   localparam logic [SEQ_W-1:0] SEQ_LAST  = 8'd255;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // capture the request transaction
      logic store_first;  // store the in-order frame at the write index
      logic sweep_step;   // deliver one more buffered frame
      logic sweep_end;    // close the sweep and ack
      logic ooo_locate;   // compute the window slot of an out-of-order frame
      logic ooo_read;     // read the tag of that slot
      logic ooo_end;      // buffer it if new, send the duplicate ack
      logic probe_ack;    // echo the probe
      logic timeout_ack;  // re-ack after the window reopened
      logic read_end;     // hand the oldest delivered word out
      logic emit_none;    // empty result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            in_order;
      logic            timeout_go;
      logic            read_avail;
      logic            sweep_more;
   } status_type;

   function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
      return (s == SEQ_LAST) ? SEQ_FIRST : s + SEQ_W'(1);
   endfunction

   function automatic logic [SEQ_W-1:0] seq_prev(input logic [SEQ_W-1:0] s);
      return (s == SEQ_FIRST) ? SEQ_LAST : s - SEQ_W'(1);
   endfunction

endpackage
`default_nettype wire

// File: rtl/selective_repeat_receive_window.sv
`timescale 1ns / 1ps
`default_nettype none
// Selective-repeat receive window for one connection. Raise start with
// req_op/req_seq_num/req_payload while busy is low; the transaction is taken
// at that clock edge. Every transaction produces exactly one result, shown
// for a single cycle with rsp_valid high; the receiver cannot stall it, so
// capture it on that edge or lose it. Result fields read zero when their own
// valid bit (rsp_ack_valid, rsp_read_valid) is low. busy drops in the cycle
// the result is shown, so the next transaction may start then.
// Probe, timeout and a read with nothing delivered end at decode; any other
// read waits on the registered data memory read; an out-of-order or rejected
// data frame goes through locate and tag check; an in-order data frame is
// stored, then the sweep delivers the m buffered frames behind it (0 to
// RECV_SLOTS-1), walking the slot tag memory one slot per cycle through its
// single registered read port. Sequence numbers run 1..255 and skip 0; after
// reset the window expects 1 and advertises RECV_SLOTS free slots.
module selective_repeat_receive_window
   import srrw_pkg::*;
#(
   parameter int RECV_SLOTS = SRRW_RECV_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [SEQ_W-1:0]  req_seq_num,
   input  wire logic [DATA_W-1:0] req_payload,
   output logic                   rsp_valid,
   output logic                   rsp_ack_valid,
   output logic [SEQ_W-1:0]       rsp_ack_seq,
   output logic [WIN_W-1:0]       rsp_ack_window,
   output logic                   rsp_read_valid,
   output logic [DATA_W-1:0]      rsp_read_data
);

   // command and status between sequencer and window datapath
   cmd_type    cmd;
   status_type status;

   // Sequence each transaction: decode, then sweep, locate or read where the op needs it.
   srrw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Hold the window state, the slot memories and the result registers.
   srrw_datapath #(
      .RECV_SLOTS (RECV_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_seq_num    (req_seq_num),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ack_valid  (rsp_ack_valid),
      .rsp_ack_seq    (rsp_ack_seq),
      .rsp_ack_window (rsp_ack_window),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_data  (rsp_read_data)
   );

endmodule
`default_nettype wire

// File: rtl/srrw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module srrw_ctrl
   import srrw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_SWEEP     = 3'd2;
   localparam logic [2:0] S_OOO_ADDR  = 3'd3;
   localparam logic [2:0] S_OOO_CHECK = 3'd4;
   localparam logic [2:0] S_READ_WAIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.op)
               OP_DATA: begin
                  if (status.in_order) begin
                     cmd.store_first = 1'b1;
                     state_in        = S_SWEEP;
                  end else begin
                     cmd.ooo_locate = 1'b1;
                     state_in       = S_OOO_ADDR;
                  end
               end
               OP_PROBE: begin
                  cmd.probe_ack = 1'b1;
                  state_in      = S_IDLE;
               end
               OP_TIMEOUT: begin
                  cmd.timeout_ack = status.timeout_go;
                  cmd.emit_none   = !status.timeout_go;
                  state_in        = S_IDLE;
               end
               OP_READ: begin
                  if (status.read_avail) begin
                     state_in = S_READ_WAIT;
                  end else begin
                     cmd.emit_none = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SWEEP: begin
            if (status.sweep_more) begin
               cmd.sweep_step = 1'b1;
            end else begin
               cmd.sweep_end = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_OOO_ADDR: begin
            cmd.ooo_read = 1'b1;
            state_in     = S_OOO_CHECK;
         end
         S_OOO_CHECK: begin
            cmd.ooo_end = 1'b1;
            state_in    = S_IDLE;
         end
         S_READ_WAIT: begin
            cmd.read_end = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/srrw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_receive_window_defines.svh"
module srrw_datapath
   import srrw_pkg::*;
#(
   parameter int RECV_SLOTS = SRRW_RECV_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [SEQ_W-1:0]  req_seq_num,
   input  wire logic [DATA_W-1:0] req_payload,
   output logic                   rsp_valid,
   output logic                   rsp_ack_valid,
   output logic [SEQ_W-1:0]       rsp_ack_seq,
   output logic [WIN_W-1:0]       rsp_ack_window,
   output logic                   rsp_read_valid,
   output logic [DATA_W-1:0]      rsp_read_data
);

   localparam int IDX_W  = (RECV_SLOTS > 1) ? $clog2(RECV_SLOTS) : 1;
   localparam int CNT_W  = $clog2(RECV_SLOTS + 1);
   localparam int DIST_W = SEQ_W + 1;
   localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(RECV_SLOTS - 1);
   localparam logic [CNT_W-1:0]  SLOTS_CNT  = CNT_W'(RECV_SLOTS);
   localparam logic [IDX_W:0]    SLOTS_WIDE = (IDX_W + 1)'(RECV_SLOTS);
   localparam logic [DIST_W-1:0] SEQ_SPAN   = DIST_W'(255);

   // captured transaction
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [DATA_W-1:0] payload_ff, payload_in;

   // window state
   logic [SEQ_W-1:0]      expected_ff, expected_in;
   logic [IDX_W-1:0]      write_index_ff, write_index_in;
   logic [IDX_W-1:0]      read_index_ff, read_index_in;
   logic [CNT_W-1:0]      free_ff, free_in;
   logic                  was_full_ff, was_full_in;
   logic [RECV_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // sweep and out-of-order working registers
   logic [IDX_W-1:0] sweep_idx_ff, sweep_idx_in;
   logic [CNT_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [SEQ_W-1:0] last_seq_ff, last_seq_in;
   logic [IDX_W-1:0] ooo_idx_ff, ooo_idx_in;
   logic             ooo_hit_ff, ooo_hit_in;

   // slot memories
   logic [SEQ_W-1:0]  tag_mem  [RECV_SLOTS];
   logic [DATA_W-1:0] data_mem [RECV_SLOTS];
   logic [SEQ_W-1:0]  tag_rd_ff;
   logic [DATA_W-1:0] data_rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [IDX_W-1:0]  tag_raddr;

   // result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ack_valid_ff, ack_valid_in;
   logic [SEQ_W-1:0]  ack_seq_ff, ack_seq_in;
   logic [WIN_W-1:0]  ack_window_ff, ack_window_in;
   logic              read_valid_ff, read_valid_in;
   logic [DATA_W-1:0] read_data_ff, read_data_in;

   logic [IDX_W-1:0]        write_next, sweep_next, read_next;
   logic [SEQ_W-1:0]        sweep_want;
   logic [DIST_W-1:0]       dist_raw, seq_gap;
   logic [IDX_W:0]          ooo_sum;
   logic [WIN_W+CNT_W-1:0]  free_ext;
   logic                    ooo_new;

   assign write_next = (write_index_ff == IDX_LAST) ? '0 : write_index_ff + IDX_W'(1);
   assign sweep_next = (sweep_idx_ff == IDX_LAST) ? '0 : sweep_idx_ff + IDX_W'(1);
   assign read_next  = (read_index_ff == IDX_LAST) ? '0 : read_index_ff + IDX_W'(1);
   assign sweep_want = seq_next(last_seq_ff);

   // distance from the expected number, modulo the 255 live numbers
   assign dist_raw = {1'b0, seq_ff} - {1'b0, expected_ff};
   assign seq_gap  = dist_raw[DIST_W-1] ? dist_raw + SEQ_SPAN : dist_raw;
   assign ooo_sum  = {1'b0, write_index_ff} + seq_gap[IDX_W:0];
   assign free_ext = {{WIN_W{1'b0}}, free_ff};
   assign ooo_new  = ooo_hit_ff && !(slot_valid_ff[ooo_idx_ff] && (tag_rd_ff == seq_ff));

   always_comb begin
      status.op         = op_ff;
      status.in_order   = (seq_ff == expected_ff) && (free_ff != '0);
      status.timeout_go = was_full_ff && (free_ff != '0);
      status.read_avail = (free_ff != SLOTS_CNT);
      status.sweep_more = (sweep_cnt_ff != SLOTS_CNT) && (free_ff != '0) &&
                          slot_valid_ff[sweep_idx_ff] && (tag_rd_ff == sweep_want);
   end

   always_comb begin
      op_in          = op_ff;
      seq_in         = seq_ff;
      payload_in     = payload_ff;
      expected_in    = expected_ff;
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      free_in        = free_ff;
      was_full_in    = was_full_ff;
      slot_valid_in  = slot_valid_ff;
      sweep_idx_in   = sweep_idx_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      last_seq_in    = last_seq_ff;
      ooo_idx_in     = ooo_idx_ff;
      ooo_hit_in     = ooo_hit_ff;
      mem_we         = 1'b0;
      mem_waddr      = write_index_ff;
      rsp_valid_in   = cmd.sweep_end | cmd.ooo_end | cmd.probe_ack | cmd.timeout_ack |
                       cmd.read_end | cmd.emit_none;
      ack_valid_in   = 1'b0;
      ack_seq_in     = '0;
      ack_window_in  = '0;
      read_valid_in  = 1'b0;
      read_data_in   = '0;

      if (cmd.load) begin
         op_in      = req_op;
         seq_in     = req_seq_num;
         payload_in = req_payload;
      end

      if (cmd.store_first) begin
         mem_we                        = 1'b1;
         slot_valid_in[write_index_ff] = 1'b1;
         free_in                       = free_ff - CNT_W'(1);
         was_full_in                   = was_full_ff | (free_ff == CNT_W'(1));
         last_seq_in                   = seq_ff;
         sweep_idx_in                  = write_next;
         sweep_cnt_in                  = CNT_W'(1);
      end

      if (cmd.sweep_step) begin
         free_in      = free_ff - CNT_W'(1);
         was_full_in  = was_full_ff | (free_ff == CNT_W'(1));
         last_seq_in  = sweep_want;
         sweep_idx_in = sweep_next;
         sweep_cnt_in = sweep_cnt_ff + CNT_W'(1);
      end

      if (cmd.sweep_end) begin
         write_index_in = sweep_idx_ff;
         expected_in    = sweep_want;
         ack_valid_in   = 1'b1;
         ack_seq_in     = last_seq_ff;
         ack_window_in  = free_ext[WIN_W-1:0];
      end

      if (cmd.ooo_locate) begin
         ooo_hit_in = (seq_ff != '0) && (seq_gap < {{(DIST_W-CNT_W){1'b0}}, free_ff});
         ooo_idx_in = (ooo_sum >= SLOTS_WIDE) ? IDX_W'(ooo_sum - SLOTS_WIDE) :
                                                ooo_sum[IDX_W-1:0];
      end

      if (cmd.ooo_end) begin
         if (ooo_new) begin
            mem_we                    = 1'b1;
            mem_waddr                 = ooo_idx_ff;
            slot_valid_in[ooo_idx_ff] = 1'b1;
         end
         ack_valid_in  = 1'b1;
         ack_seq_in    = seq_prev(expected_ff);
         ack_window_in = free_ext[WIN_W-1:0];
      end

      if (cmd.probe_ack) begin
         ack_valid_in  = 1'b1;
         ack_seq_in    = seq_ff;
         ack_window_in = free_ext[WIN_W-1:0];
      end

      if (cmd.timeout_ack) begin
         was_full_in   = 1'b0;
         ack_valid_in  = 1'b1;
         ack_seq_in    = seq_prev(expected_ff);
         ack_window_in = free_ext[WIN_W-1:0];
      end

      if (cmd.read_end) begin
         slot_valid_in[read_index_ff] = 1'b0;
         read_index_in                = read_next;
         free_in                      = free_ff + CNT_W'(1);
         read_valid_in                = 1'b1;
         read_data_in                 = data_rd_ff;
      end
   end

   always_comb begin
      if (cmd.ooo_read) begin
         tag_raddr = ooo_idx_ff;
      end else if (cmd.store_first) begin
         tag_raddr = write_next;
      end else begin
         tag_raddr = sweep_next;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr]  <= seq_ff;
         data_mem[mem_waddr] <= payload_ff;
      end
      tag_rd_ff  <= tag_mem[tag_raddr];
      data_rd_ff <= data_mem[read_index_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff    <= SEQ_FIRST;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         free_ff        <= SLOTS_CNT;
         was_full_ff    <= 1'b0;
         slot_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         expected_ff    <= expected_in;
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         free_ff        <= free_in;
         was_full_ff    <= was_full_in;
         slot_valid_ff  <= slot_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      seq_ff        <= seq_in;
      payload_ff    <= payload_in;
      sweep_idx_ff  <= sweep_idx_in;
      sweep_cnt_ff  <= sweep_cnt_in;
      last_seq_ff   <= last_seq_in;
      ooo_idx_ff    <= ooo_idx_in;
      ooo_hit_ff    <= ooo_hit_in;
      ack_valid_ff  <= ack_valid_in;
      ack_seq_ff    <= ack_seq_in;
      ack_window_ff <= ack_window_in;
      read_valid_ff <= read_valid_in;
      read_data_ff  <= read_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ack_valid  = ack_valid_ff;
   assign rsp_ack_seq    = ack_seq_ff;
   assign rsp_ack_window = ack_window_ff;
   assign rsp_read_valid = read_valid_ff;
   assign rsp_read_data  = read_data_ff;

   `SRRW_ASSERT_IMPLY(a_free_bound, 1'b1, free_ff <= SLOTS_CNT)
   `SRRW_ASSERT_IMPLY(a_expected_live, 1'b1, expected_ff != '0)
   `SRRW_ASSERT_NEXT(a_result_single_cycle, rsp_valid_ff, !rsp_valid_ff)
   `SRRW_ASSERT_IMPLY(a_read_not_ack, rsp_valid_ff && read_valid_ff, !ack_valid_ff)

endmodule
`default_nettype wire

// File: tb/sv/tb_selective_repeat_receive_window.sv
`timescale 1ns / 1ps
module tb_selective_repeat_receive_window;
   import srrw_pkg::*;

   localparam int SLOTS        = SRRW_RECV_SLOTS_DEF;
   // Longest sender gap plus the slowest transaction (full sweep) fits many times over.
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_GAP      = 64;
   // Slowest transaction is an in-order frame sweeping every slot.
   localparam int DRAIN_CYCLES = SLOTS + 8;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 570;

   localparam logic [DATA_W-1:0] WORD_ZERO = '0;
   localparam logic [DATA_W-1:0] WORD_ONES = '1;

   // One result transaction, laid out field by field as on the rsp_ ports.
   typedef struct packed {
      logic              ack_valid;
      logic [SEQ_W-1:0]  ack_seq;
      logic [WIN_W-1:0]  ack_window;
      logic              read_valid;
      logic [DATA_W-1:0] read_data;
   } window_response_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [OP_W-1:0]   req_op;
   logic [SEQ_W-1:0]  req_seq_num;
   logic [DATA_W-1:0] req_payload;
   logic              rsp_valid;
   logic              rsp_ack_valid;
   logic [SEQ_W-1:0]  rsp_ack_seq;
   logic [WIN_W-1:0]  rsp_ack_window;
   logic              rsp_read_valid;
   logic [DATA_W-1:0] rsp_read_data;

   selective_repeat_receive_window #(
      .RECV_SLOTS(SLOTS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_seq_num   (req_seq_num),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ack_valid (rsp_ack_valid),
      .rsp_ack_seq   (rsp_ack_seq),
      .rsp_ack_window(rsp_ack_window),
      .rsp_read_valid(rsp_read_valid),
      .rsp_read_data (rsp_read_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Window predictor state: a private copy of the receive window.
   // ------------------------------------------------------------------
   logic              slot_held [SLOTS];
   logic [SEQ_W-1:0]  slot_seq  [SLOTS];
   logic [DATA_W-1:0] slot_word [SLOTS];
   logic [SEQ_W-1:0]  next_expected;
   int unsigned       write_ptr;
   int unsigned       read_ptr;
   int unsigned       free_count;
   bit                full_seen;

   // Responses predicted for accepted transactions, oldest first.
   window_response_type  awaited_responses [$];

   int unsigned failures;
   int unsigned stall_cycles;
   int unsigned idle_pct;

   // Step a sequence number forward n times; 0 is never produced, 255 wraps to 1.
   function automatic logic [SEQ_W-1:0] seq_after(input logic [SEQ_W-1:0] s,
                                                  input int unsigned n);
      logic [SEQ_W-1:0] r;
      r = s;
      repeat (n) r = (r == SEQ_LAST) ? SEQ_FIRST : r + 1'b1;
      return r;
   endfunction

   // Last number delivered in order; right after a wrap (or reset) that is 255.
   function automatic logic [SEQ_W-1:0] last_delivered();
      return (next_expected == SEQ_FIRST) ? SEQ_LAST : next_expected - 1'b1;
   endfunction

   // Consume one free slot and remember that the window closed.
   function automatic void claim_slot();
      if (free_count > 0) free_count--;
      if (free_count == 0) full_seen = 1'b1;
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < SLOTS; i++) begin
         slot_held[i] = 1'b0;
         slot_seq[i]  = '0;
         slot_word[i] = '0;
      end
      next_expected = SEQ_FIRST;
      write_ptr     = 0;
      read_ptr      = 0;
      free_count    = SLOTS;
      full_seen     = 1'b0;
   endfunction

   // Advance the window by one accepted transaction and return its response.
   function automatic window_response_type predict_window_response(
      input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] word);
      window_response_type r;
      logic [SEQ_W-1:0] last;
      logic [SEQ_W-1:0] scan_seq;
      int unsigned      last_idx;
      int unsigned      idx;
      bit               open;
      r = '0;
      case (op)
         OP_DATA: begin
            if (seq == next_expected && free_count > 0) begin
               // Store the in-order frame, then sweep over buffered successors.
               last     = seq;
               last_idx = write_ptr;
               slot_held[last_idx] = 1'b1;
               slot_seq[last_idx]  = seq;
               slot_word[last_idx] = word;
               claim_slot();
               open = 1'b1;
               for (int k = 1; k < SLOTS; k++) begin
                  idx = (write_ptr + k) % SLOTS;
                  if (open && free_count > 0 && slot_held[idx]
                      && slot_seq[idx] == seq_after(last, 1)) begin
                     last     = seq_after(last, 1);
                     last_idx = idx;
                     claim_slot();
                  end else begin
                     open = 1'b0;
                  end
               end
               write_ptr     = (last_idx + 1) % SLOTS;
               next_expected = seq_after(last, 1);
               r.ack_seq     = last;
            end else begin
               // Buffer an in-window frame once; anything else only re-acks.
               scan_seq = next_expected;
               open     = 1'b1;
               for (int k = 0; k < free_count && k < SLOTS; k++) begin
                  if (open && seq == scan_seq) begin
                     idx = (write_ptr + k) % SLOTS;
                     if (!(slot_held[idx] && slot_seq[idx] == seq)) begin
                        slot_held[idx] = 1'b1;
                        slot_seq[idx]  = seq;
                        slot_word[idx] = word;
                     end
                     open = 1'b0;
                  end
                  scan_seq = seq_after(scan_seq, 1);
               end
               r.ack_seq = last_delivered();
            end
            r.ack_valid  = 1'b1;
            r.ack_window = WIN_W'(free_count);
         end
         OP_PROBE: begin
            r.ack_valid  = 1'b1;
            r.ack_seq    = seq;
            r.ack_window = WIN_W'(free_count);
         end
         OP_TIMEOUT: begin
            if (full_seen && free_count > 0) begin
               r.ack_valid  = 1'b1;
               r.ack_seq    = last_delivered();
               r.ack_window = WIN_W'(free_count);
               full_seen    = 1'b0;
            end
         end
         default: begin
            // Application read: hand out the oldest delivered word and free its slot.
            if (free_count < SLOTS) begin
               r.read_valid        = 1'b1;
               r.read_data         = slot_word[read_ptr];
               slot_held[read_ptr] = 1'b0;
               read_ptr            = (read_ptr + 1) % SLOTS;
               free_count++;
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic string show_response(input window_response_type r);
      return $sformatf("ack %0b seq %0d win %0d read %0b data %h",
                       r.ack_valid, r.ack_seq, r.ack_window, r.read_valid, r.read_data);
   endfunction

   task automatic note_failure(input string text);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t: %s", $realtime, text);
   endtask

   // ------------------------------------------------------------------
   // Send one request transaction. Call at a rising edge; returns at the
   // edge that accepted it, with start still high so a following call
   // can present the next transaction without a bubble.
   // ------------------------------------------------------------------
   task automatic send_frame(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                             input logic [DATA_W-1:0] word);
      int unsigned gap;
      bit          taken;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      // Hold start low for the sender gap, then present the transaction.
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op      <= op;
      req_seq_num <= seq;
      req_payload <= word;
      start       <= 1'b1;
      // Check busy mid-cycle, where it is stable; low there means the next edge takes it.
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      awaited_responses.push_back(predict_window_response(op, seq, word));
   endtask

   // ------------------------------------------------------------------
   // Random traffic: mostly frames inside or at the edge of the window,
   // with reads to reopen it, probes, timeout ticks and some noise.
   // ------------------------------------------------------------------
   task automatic drive_traffic(input int unsigned count);
      int unsigned pick;
      int unsigned read_weight;
      int unsigned offset;
      logic [SEQ_W-1:0] seq;
      read_weight = 25;
      for (int n = 0; n < count; n++) begin
         // Shift the read rate now and then so the window both fills and drains.
         if (n % 100 == 0) read_weight = $urandom_range(10, 45);
         pick = $urandom_range(99);
         if (pick < read_weight) begin
            send_frame(OP_READ, SEQ_W'($urandom), rand_word());
         end else if (pick < read_weight + 8) begin
            send_frame(OP_PROBE, SEQ_W'($urandom), rand_word());
         end else if (pick < read_weight + 16) begin
            send_frame(OP_TIMEOUT, SEQ_W'($urandom), rand_word());
         end else if (pick < read_weight + 24) begin
            // Noise: any number at all, or a retransmit from behind the window.
            if ($urandom_range(1) == 0) seq = SEQ_W'($urandom);
            else seq = seq_after(next_expected, 255 - $urandom_range(1, 20));
            send_frame(OP_DATA, seq, rand_word());
         end else begin
            // Well-formed: the expected number or one ahead of it, up to the window's edge.
            if (free_count == 0 || $urandom_range(2) == 0) offset = 0;
            else offset = $urandom_range(free_count);
            send_frame(OP_DATA, seq_after(next_expected, offset), rand_word());
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, every op and the corner cases, from a fresh window.
   task automatic test_directed();
      idle_pct = 0;
      send_frame(OP_PROBE,   8'd0,   WORD_ZERO);   // probe echoes zero too
      send_frame(OP_PROBE,   8'd255, WORD_ONES);
      send_frame(OP_TIMEOUT, 8'd0,   WORD_ZERO);   // window never closed: silent
      send_frame(OP_READ,    8'd255, WORD_ONES);   // nothing delivered: empty read
      send_frame(OP_DATA,    8'd0,   WORD_ZERO);   // zero never matches; re-ack 255
      send_frame(OP_DATA,    8'd1,   WORD_ONES);   // in order
      send_frame(OP_DATA,    8'd3,   WORD_ZERO);   // ahead: buffer it
      send_frame(OP_DATA,    8'd3,   rand_word()); // already buffered: keep first word
      send_frame(OP_DATA,    8'd200, rand_word()); // outside the window
      send_frame(OP_DATA,    8'd2,   rand_word()); // in order, sweeps up 3
      // Buffer the rest of the window backwards, then close it with one long sweep.
      for (int s = 16; s >= 5; s--) send_frame(OP_DATA, SEQ_W'(s), rand_word());
      send_frame(OP_DATA,    8'd4,   rand_word());
      send_frame(OP_DATA,    8'd17,  rand_word()); // expected number, but window full
      send_frame(OP_TIMEOUT, 8'd0,   WORD_ZERO);   // still full: silent
      send_frame(OP_READ,    8'd0,   WORD_ZERO);   // returns the all-ones word
      send_frame(OP_TIMEOUT, 8'd0,   WORD_ZERO);   // reopened: re-ack
      send_frame(OP_TIMEOUT, 8'd0,   WORD_ZERO);   // only once
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      drive_traffic(PHASE_ITEMS);
   endtask

   task automatic test_sparse_sender();
      idle_pct = 82;
      drive_traffic(PHASE_ITEMS);
   endtask

   task automatic test_mixed_idle();
      idle_pct = 28;
      drive_traffic(PHASE_ITEMS);
   endtask

   // ------------------------------------------------------------------
   // Response checker and stall counter. Sample at the rising edge, before
   // any driver update lands, so each strobe is seen exactly once.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : response_check
      window_response_type seen;
      window_response_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (rsp_valid) begin
            seen.ack_valid  = rsp_ack_valid;
            seen.ack_seq    = rsp_ack_seq;
            seen.ack_window = rsp_ack_window;
            seen.read_valid = rsp_read_valid;
            seen.read_data  = rsp_read_data;
            if (awaited_responses.size() == 0) begin
               note_failure({"unexpected response: ", show_response(seen)});
            end else begin
               want = awaited_responses.pop_front();
               if (seen !== want)
                  note_failure({"response mismatch: expected ", show_response(want),
                                " got ", show_response(seen)});
            end
         end
      end
   end

   // Drop the run if nothing moves for too long.
   initial begin : stall_watch
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb_selective_repeat_receive_window: FAIL");
      $finish;
   end

   initial begin : run_tests
      reset        = 1'b1;
      start        = 1'b0;
      req_op       = OP_DATA;
      req_seq_num  = '0;
      req_payload  = '0;
      idle_pct     = 0;
      failures     = 0;
      stall_cycles = 0;
      clear_window();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_back_to_back();
      test_sparse_sender();
      test_mixed_idle();

      // Drain: wait out every predicted response, then watch for strays.
      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("tb_selective_repeat_receive_window: PASS");
      else
         $display("tb_selective_repeat_receive_window: FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/srrw_pkg.sv
rtl/srrw_ctrl.sv
rtl/srrw_datapath.sv
rtl/selective_repeat_receive_window.sv
tb/sv/tb_selective_repeat_receive_window.sv
